[rtl/lcgr_pkg.sv]
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared types and constants of the ranged LCG random generator.
// ----------------------------------------------------------------------------
package lcgr_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 3;
    localparam int unsigned RegIdxW = 2;
    localparam int unsigned StepW = 5;

    localparam int unsigned RotLeft  = 12;
    localparam int unsigned RotRight = 20;

    localparam int unsigned InDataW  = 104;
    localparam int unsigned OutDataW = 72;

    localparam logic [WordW-1:0] MultReset = 32'd46341;
    localparam logic [WordW-1:0] IncrReset = 32'd1;
    localparam logic [WordW-1:0] MaskReset = 32'h7FFF_FFFF;
    localparam logic [WordW-1:0] SeedReset = 32'd1;

    localparam logic [StepW-1:0] LastStep = 5'd31;

    typedef enum logic [OpW-1:0] {
        OP_RAW      = 3'd0,
        OP_LOW_BITS = 3'd1,
        OP_MODULO   = 3'd2,
        OP_RANGE    = 3'd3,
        OP_FRACTION = 3'd4
    } opcode_t;

    typedef enum logic [RegIdxW-1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_INCREMENT  = 2'd1,
        REG_MASK       = 2'd2,
        REG_SEED       = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic add;
        logic prep;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

[rtl/lcgr_ctrl.sv]
// ----------------------------------------------------------------------------
// lcgr_ctrl
// Sequencer for one request: multiply, add, divider setup, 32 divide
// steps and the load of the output register.
// ----------------------------------------------------------------------------
module lcgr_ctrl
    import lcgr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t      state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_PREP;
            ST_PREP: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LastStep) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL:  cmd.mul = 1'b1;
            ST_ADD:  cmd.add = 1'b1;
            ST_PREP: cmd.prep = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_DONE: cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/lcgr_datapath.sv]
// ----------------------------------------------------------------------------
// lcgr_datapath
// Configuration registers, generator state, multiplier, shared restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module lcgr_datapath
    import lcgr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                cfg_valid,
    input  logic [RegIdxW-1:0]  cfg_index,
    input  logic [WordW-1:0]    cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    input  dp_cmd_t             cmd,
    output dp_status_t          status
);

    logic [WordW-1:0] mult_reg, incr_reg, mask_reg, gen_reg;
    logic [WordW-1:0] prod_reg;
    logic [OpW-1:0]   op_reg;
    logic [WordW-1:0] limit_reg, bound_a_reg, bound_b_reg;
    logic [WordW-1:0] divisor_reg, rem_reg, quo_reg, lo_reg;
    logic             zero_reg;
    logic             out_valid_reg;
    logic [WordW-1:0] out_uval_reg, out_sval_reg;
    logic             out_status_reg;

    logic [WordW-1:0] rot;
    logic [WordW-1:0] lo_calc, hi_calc, span_calc, divisor_calc;
    logic [WordW:0]   trial_sh, trial_diff;
    logic             trial_ok;
    logic [WordW-1:0] uval_calc, sval_calc, low_mask;

    assign rot = {gen_reg[WordW-RotLeft-1:0], gen_reg[WordW-1:RotRight]};

    always_comb begin
        if ($signed(bound_a_reg) < $signed(bound_b_reg)) begin
            lo_calc = bound_a_reg;
            hi_calc = bound_b_reg;
        end else begin
            lo_calc = bound_b_reg;
            hi_calc = bound_a_reg;
        end
        span_calc = hi_calc - lo_calc;
        case (op_reg)
            OP_MODULO:   divisor_calc = limit_reg;
            OP_RANGE:    divisor_calc = span_calc;
            OP_FRACTION: divisor_calc = mask_reg;
            default:     divisor_calc = mask_reg;
        endcase
    end

    assign trial_sh   = {rem_reg, quo_reg[WordW-1]};
    assign trial_diff = trial_sh - {1'b0, divisor_reg};
    assign trial_ok   = (trial_sh >= {1'b0, divisor_reg});

    always_comb begin
        low_mask  = ~({WordW{1'b1}} << limit_reg[StepW-1:0]);
        uval_calc = '0;
        sval_calc = '0;
        case (op_reg)
            OP_LOW_BITS: begin
                if (limit_reg >= WordW) begin
                    uval_calc = gen_reg;
                end else begin
                    uval_calc = gen_reg & low_mask;
                end
            end
            OP_MODULO:   uval_calc = zero_reg ? '0 : rem_reg;
            OP_RANGE:    sval_calc = zero_reg ? '0 : lo_reg + rem_reg;
            OP_FRACTION: uval_calc = zero_reg ? '0 : quo_reg;
            default:     uval_calc = gen_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= MultReset;
            incr_reg <= IncrReset;
            mask_reg <= MaskReset;
            gen_reg  <= SeedReset;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MULTIPLIER: mult_reg <= cfg_data;
                    REG_INCREMENT:  incr_reg <= cfg_data;
                    REG_MASK:       mask_reg <= cfg_data;
                    REG_SEED:       gen_reg  <= cfg_data;
                    default: ;
                endcase
            end else if (cmd.add) begin
                gen_reg <= (prod_reg + incr_reg) & mask_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg      <= s_tdata[OpW-1:0];
            limit_reg   <= s_tdata[OpW+WordW-1:OpW];
            bound_a_reg <= s_tdata[OpW+2*WordW-1:OpW+WordW];
            bound_b_reg <= s_tdata[OpW+3*WordW-1:OpW+2*WordW];
        end
        if (cmd.mul) begin
            prod_reg <= mult_reg * rot;
        end
        if (cmd.prep) begin
            divisor_reg <= divisor_calc;
            zero_reg    <= (divisor_calc == '0);
            lo_reg      <= lo_calc;
            if (op_reg == OP_FRACTION) begin
                rem_reg <= {1'b0, gen_reg[WordW-1:1]};
                quo_reg <= {gen_reg[0], {(WordW-1){1'b0}}};
            end else begin
                rem_reg <= '0;
                quo_reg <= gen_reg;
            end
        end else if (cmd.div_step) begin
            if (trial_ok) begin
                rem_reg <= trial_diff[WordW-1:0];
            end else begin
                rem_reg <= trial_sh[WordW-1:0];
            end
            quo_reg <= {quo_reg[WordW-2:0], trial_ok};
        end
        if (cmd.out_load) begin
            out_uval_reg   <= uval_calc;
            out_sval_reg   <= sval_calc;
            out_status_reg <= zero_reg &&
                              (op_reg == OP_MODULO || op_reg == OP_RANGE ||
                               op_reg == OP_FRACTION);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-2*WordW-1){1'b0}}, out_status_reg,
                       out_sval_reg, out_uval_reg};

endmodule

[rtl/lcg_random_ranged_core.sv]
// ----------------------------------------------------------------------------
// lcg_random_ranged_core
// Ranged 32-bit linear congruential random generator with a
// configuration write port.
// ----------------------------------------------------------------------------
// Each accepted request advances the generator and returns one word. A
// request runs through one multiply, one add and mask, one divider setup
// step and 32 steps of the bit-serial divider, which are run for every
// opcode, and its result is loaded once the output register is free. A
// new request is taken in the cycle after its predecessor's result is
// loaded into the output register, even if that word has not been taken
// yet. Configuration writes are always accepted and must be made only
// while no request is in flight; writing the seed reloads the state.
// ----------------------------------------------------------------------------
module lcg_random_ranged_core
    import lcgr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode[2:0], limit[34:3], bound_a[66:35], bound_b[98:67], zero pad
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // unsigned_value[31:0], signed_value[63:32], status[64], zero pad
    output logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RegIdxW-1:0]  cfg_index,
    input  logic [WordW-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lcgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lcgr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // Once a word is accepted, s_tready is checked to stay low through the following MUL and ADD states.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted while a computation is in flight");

    // A zero divisor in the modulo, range and fraction modes forces both result fields to zero.
    a_zero_on_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*WordW] |-> m_tdata[2*WordW-1:0] == '0)
        else $error("status set with a nonzero result");

    // The output register is never reloaded while it still holds a word.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> !$rose(s_tready) || !m_tvalid)
        else $error("output word overwritten before it was taken");

endmodule
